FILE: hdl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// Polygon area package
// Types and fixed constants shared by the polygon area block and its
// multiplier.
// ----------------------------------------------------------------------------
package mpa_pkg;

	localparam int COORD_W  = 30;
	localparam int DIFF_W   = 31;
	localparam int SUM_W    = 64;
	localparam int MAG_W    = 63;
	localparam int SCALE_W  = 47;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;
	localparam int ACC_W    = 110;
	localparam int AREA_W   = 53;
	localparam int COUNT_W  = 16;
	localparam int ZOOM_W   = 5;
	localparam int SHIFT_W  = 6;
	localparam int HALF_W   = 32;

	// Square of the earth's circumference in metres, with 8 fraction bits.
	localparam logic [63:0] CIRC_SQ_Q8 = 64'd410218188239090765;

	localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [SHIFT_W-1:0] SHIFT_BASE = 6'd9;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_TERM,
		ST_SUM,
		ST_ABS,
		ST_SC0,
		ST_SC1,
		ST_SC2,
		ST_SC3,
		ST_SC4,
		ST_FIN
	} mpa_state_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mpa_mul_op_t;

endpackage

FILE: hdl/mpa_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 bit multiplier with a registered product, used in turn for
// the cross products and for the partial products of the area scaling.
// ----------------------------------------------------------------------------
module mpa_mul (
	input  logic                         clk,
	input  mpa_pkg::mpa_mul_op_t         op,
	output logic signed [mpa_pkg::PROD_W-1:0] prod_q
);
	import mpa_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op.a) * PROD_W'(op.b);
	end

endmodule

FILE: hdl/mercator_polygon_area_top.sv
// ----------------------------------------------------------------------------
// Mercator polygon area
// Shoelace area of a polygon given as world-pixel vertices, scaled to square
// metres for the current map zoom, with saturation of the sum and the area.
// ----------------------------------------------------------------------------
// One vertex is taken per request and one result is returned for each. A
// vertex that continues a polygon passes through the cross product states
// before the scaling, and a vertex that starts a polygon goes straight to the
// scaling. The single shared 33 by 33 bit multiplier forms the two cross
// products and then the four partial products of the scaling, one per cycle.
// The result waits in an output register, so a new vertex may be accepted
// while it is still stalled. The zoom register must be written only while the
// block is idle; the block itself does not enforce this.
module mercator_polygon_area_top #(
	parameter int TILE_PIXELS = 256,
	parameter int MAX_ZOOM    = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpa_pkg::ZOOM_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mpa_pkg::COORD_W-1:0]       point_x,
	input  logic [mpa_pkg::COORD_W-1:0]       point_y,
	input  logic                              new_polygon,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mpa_pkg::AREA_W-1:0]        area_square_m,
	output logic [mpa_pkg::COUNT_W-1:0]       vertex_count,
	output logic                              saturated
);
	import mpa_pkg::*;

	localparam logic [63:0] SCALE_FULL = CIRC_SQ_Q8 / 64'(TILE_PIXELS * TILE_PIXELS);
	localparam logic [SCALE_W-1:0] SCALE = SCALE_FULL[SCALE_W-1:0];
	localparam logic [ZOOM_W-1:0] ZOOM_MAX = ZOOM_W'(MAX_ZOOM);
	localparam logic signed [SUM_W:0] SUM_HI = {1'b0, SUM_MAX};
	localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI;

	mpa_state_t state_q, state_d;

	logic [ZOOM_W-1:0]         zoom_q;
	logic [COORD_W-1:0]        first_x_q, first_y_q;
	logic signed [DIFF_W-1:0]  prev_dx_q, prev_dy_q, dx_q, dy_q;
	logic signed [SUM_W-1:0]   sum_q, term_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      ovf_q;
	logic [MAG_W-1:0]          mag_q;
	logic [ACC_W-1:0]          acc_q;
	logic [SHIFT_W-1:0]        shift_q;
	logic                      out_valid_q;
	logic [AREA_W-1:0]         area_q;
	logic [COUNT_W-1:0]        vcount_q;
	logic                      sat_q;

	mpa_mul_op_t               mul_op;
	logic signed [PROD_W-1:0]  prod;

	logic                      accept, start, out_free;
	logic signed [SUM_W:0]     sum_ext;
	logic [ACC_W-1:0]          shifted;
	logic                      area_over;
	logic [ZOOM_W-1:0]         zoom_eff;
	logic [ACC_W-1:0]          prod_u;

	mpa_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod)
	);

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign start         = new_polygon || (count_q == '0);
	assign out_free      = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign area_square_m = area_q;
	assign vertex_count  = vcount_q;
	assign saturated     = sat_q;

	assign sum_ext   = {sum_q[SUM_W-1], sum_q} + {term_q[SUM_W-1], term_q};
	assign zoom_eff  = (zoom_q > ZOOM_MAX) ? ZOOM_MAX : zoom_q;
	assign shifted   = acc_q >> shift_q;
	assign area_over = |shifted[ACC_W-1:AREA_W];
	assign prod_u    = ACC_W'(prod[SUM_W-1:0]);

	always_comb begin
		mul_op = '0;
		case (state_q)
			ST_MUL_A: begin
				mul_op.a = MUL_W'(prev_dx_q);
				mul_op.b = MUL_W'(dy_q);
			end
			ST_MUL_B: begin
				mul_op.a = MUL_W'(dx_q);
				mul_op.b = MUL_W'(prev_dy_q);
			end
			ST_SC0: begin
				mul_op.a = {1'b0, mag_q[HALF_W-1:0]};
				mul_op.b = {1'b0, SCALE[HALF_W-1:0]};
			end
			ST_SC1: begin
				mul_op.a = {1'b0, mag_q[HALF_W-1:0]};
				mul_op.b = MUL_W'(SCALE[SCALE_W-1:HALF_W]);
			end
			ST_SC2: begin
				mul_op.a = MUL_W'(mag_q[MAG_W-1:HALF_W]);
				mul_op.b = {1'b0, SCALE[HALF_W-1:0]};
			end
			ST_SC3: begin
				mul_op.a = MUL_W'(mag_q[MAG_W-1:HALF_W]);
				mul_op.b = MUL_W'(SCALE[SCALE_W-1:HALF_W]);
			end
			default: begin
				mul_op = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = start ? ST_ABS : ST_MUL_A;
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_TERM;
			ST_TERM:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_ABS;
			ST_ABS:   state_d = ST_SC0;
			ST_SC0:   state_d = ST_SC1;
			ST_SC1:   state_d = ST_SC2;
			ST_SC2:   state_d = ST_SC3;
			ST_SC3:   state_d = ST_SC4;
			ST_SC4:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zoom_q      <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_dx_q   <= '0;
			prev_dy_q   <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) zoom_q <= cfg_wdata;
			if (accept && start) begin
				first_x_q <= point_x;
				first_y_q <= point_y;
				prev_dx_q <= '0;
				prev_dy_q <= '0;
				sum_q     <= '0;
				count_q   <= COUNT_W'(1);
				ovf_q     <= 1'b0;
			end
			if (state_q == ST_SUM) begin
				if (sum_ext > SUM_HI) begin
					sum_q <= SUM_MAX;
					ovf_q <= 1'b1;
				end else if (sum_ext < SUM_LO) begin
					sum_q <= SUM_LO[SUM_W-1:0];
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
				prev_dx_q <= dx_q;
				prev_dy_q <= dy_q;
				if (count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !start) begin
			dx_q <= $signed({1'b0, point_x}) - $signed({1'b0, first_x_q});
			dy_q <= $signed({1'b0, point_y}) - $signed({1'b0, first_y_q});
		end
		case (state_q)
			ST_MUL_B: term_q <= prod[SUM_W-1:0];
			ST_TERM:  term_q <= term_q - prod[SUM_W-1:0];
			ST_ABS: begin
				mag_q   <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : sum_q[MAG_W-1:0];
				shift_q <= SHIFT_BASE + {zoom_eff, 1'b0};
			end
			ST_SC1:   acc_q <= prod_u;
			ST_SC2:   acc_q <= acc_q + (prod_u << HALF_W);
			ST_SC3:   acc_q <= acc_q + (prod_u << HALF_W);
			ST_SC4:   acc_q <= acc_q + (prod_u << (2 * HALF_W));
			ST_FIN: begin
				if (out_free) begin
					area_q   <= area_over ? AREA_MAX : shifted[AREA_W-1:0];
					vcount_q <= count_q;
					sat_q    <= ovf_q || area_over;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/mpa_checker.sv
// ----------------------------------------------------------------------------
// Polygon area port checker
// Watches the ports of the polygon area block and checks its request
// handling and some properties of its results over time.
// ----------------------------------------------------------------------------
module mpa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mpa_pkg::AREA_W-1:0]   area_square_m,
	input logic [mpa_pkg::COUNT_W-1:0]  vertex_count,
	input logic                         saturated
);
	import mpa_pkg::*;

	// A vertex keeps the block busy for the following cycle.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready straight after accepting a request");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vertex_count != '0)
		else $error("result with a vertex count of zero");

	// Fewer than three vertices enclose no area.
	a_small_polygon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vertex_count < COUNT_W'(3) |-> area_square_m == '0)
		else $error("non-zero area for fewer than three vertices");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(area_square_m)
			&& $stable(vertex_count) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind mercator_polygon_area_top mpa_checker u_mpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.area_square_m (area_square_m),
	.vertex_count  (vertex_count),
	.saturated     (saturated)
);

FILE: dv/mercator_polygon_area_top_test.sv
// ----------------------------------------------------------------------------
// Mercator polygon area testbench
// Drives vertices into the polygon area block with random gaps and output
// stalls, predicts every result from a model of the shoelace sum and the zoom
// scaling held in a scoreboard, and compares each result field by field.
// Zoom settings and sum and area saturation are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mercator_polygon_area_top_test;

	import mpa_pkg::*;

	localparam int TILE        = 256;
	localparam int ZOOM_LIMIT  = 22;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 100;
	localparam int PHASE_ITEMS    = 55;

	localparam logic [63:0] PX_SCALE = CIRC_SQ_Q8 / (64'(TILE) * 64'(TILE));
	localparam longint SUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_TOP = {COORD_W{1'b1}};
	localparam logic [COORD_W-1:0] CENTRE    = 30'h2000_0000;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [COUNT_W-1:0] count;
		logic               saturated;
	} area_result_t;

	class area_scoreboard;
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		longint             prev_dx;
		longint             prev_dy;
		longint             cross_sum;
		logic [COUNT_W-1:0] count;
		bit                 overflow_seen;
		area_result_t       pending_areas[$];
		int                 errors;
		int                 reports;

		function new();
			zoom = '0;
			first_x = '0;
			first_y = '0;
			prev_dx = 0;
			prev_dy = 0;
			cross_sum = 0;
			count = '0;
			overflow_seen = 0;
			errors = 0;
			reports = 0;
		endfunction

		function void set_zoom(logic [ZOOM_W-1:0] z);
			zoom = z;
		endfunction

		function int pending();
			return pending_areas.size();
		endfunction

		function logic [AREA_W-1:0] square_metres(logic [63:0] mag, output bit clamped);
			logic [127:0] prod;
			logic [127:0] scaled;
			int unsigned  z;
			z = (zoom > ZOOM_LIMIT) ? ZOOM_LIMIT : zoom;
			prod = {64'd0, mag} * {64'd0, PX_SCALE};
			scaled = prod >> (9 + 2 * z);
			clamped = scaled > {75'd0, AREA_MAX};
			return clamped ? AREA_MAX : scaled[AREA_W-1:0];
		endfunction

		function void note_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic np);
			longint       dx;
			longint       dy;
			longint       term;
			logic [63:0]  mag;
			bit           clamped;
			area_result_t r;
			if (np || count == 0) begin
				first_x = x;
				first_y = y;
				prev_dx = 0;
				prev_dy = 0;
				cross_sum = 0;
				count = 1;
				overflow_seen = 0;
			end else begin
				dx = longint'({34'd0, x}) - longint'({34'd0, first_x});
				dy = longint'({34'd0, y}) - longint'({34'd0, first_y});
				term = prev_dx * dy - dx * prev_dy;
				if (term > 0 && cross_sum > SUM_LIMIT - term) begin
					cross_sum = SUM_LIMIT;
					overflow_seen = 1;
				end else if (term < 0 && cross_sum < -SUM_LIMIT - term) begin
					cross_sum = -SUM_LIMIT;
					overflow_seen = 1;
				end else begin
					cross_sum = cross_sum + term;
				end
				prev_dx = dx;
				prev_dy = dy;
				if (count != COUNT_MAX)
					count = count + COUNT_W'(1);
			end
			mag = (cross_sum < 0) ? 64'(-cross_sum) : 64'(cross_sum);
			r.area = square_metres(mag, clamped);
			r.count = count;
			r.saturated = overflow_seen || clamped;
			pending_areas.insert(pending_areas.size(), r);
		endfunction

		function void mismatch(string field, longint unsigned want, longint unsigned got);
			errors++;
			if (reports < REPORT_LIMIT)
				$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			reports++;
		endfunction

		function void check_result(area_result_t got);
			area_result_t want;
			if (pending_areas.size() == 0) begin
				errors++;
				if (reports < REPORT_LIMIT)
					$display("%0t: result with no request waiting, actual area %0d count %0d",
						$time, got.area, got.count);
				reports++;
				return;
			end
			want = pending_areas.pop_front();
			if (got.area !== want.area)
				mismatch("area_square_m", want.area, got.area);
			if (got.count !== want.count)
				mismatch("vertex_count", want.count, got.count);
			if (got.saturated !== want.saturated)
				mismatch("saturated", want.saturated, got.saturated);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [ZOOM_W-1:0]  cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic               new_polygon;
	logic               out_valid;
	logic               out_stall;
	logic [AREA_W-1:0]  area_square_m;
	logic [COUNT_W-1:0] vertex_count;
	logic               saturated;

	area_scoreboard sb;
	bit             gap_en;
	bit             stall_en;
	int             stall_left;
	int             idle_cycles;
	int             vertices_sent;

	mercator_polygon_area_top #(
		.TILE_PIXELS(TILE),
		.MAX_ZOOM   (ZOOM_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.new_polygon  (new_polygon),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.area_square_m(area_square_m),
		.vertex_count (vertex_count),
		.saturated    (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// The output side stalls in stretches of random length.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall = 1'b0;
			if (stall_en)
				stall_left = rand_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{area: area_square_m, count: vertex_count, saturated: saturated});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mercator_polygon_area_top_test: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic np);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		point_x = x;
		point_y = y;
		new_polygon = np;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_vertex(x, y, np);
		vertices_sent++;
		gap = gap_en ? rand_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_zoom(logic [ZOOM_W-1:0] z);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = z;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_zoom(z);
	endtask

	task automatic send_square(logic np);
		send_vertex('0, '0, np);
		send_vertex(COORD_TOP, '0, 1'b0);
		send_vertex(COORD_TOP, COORD_TOP, 1'b0);
		send_vertex('0, COORD_TOP, 1'b0);
	endtask

	// Corners taken in turn around the centre, so that every cross product has
	// the same sign and the sum runs into its limit.
	task automatic send_winding();
		int                 n;
		bit                 ccw;
		int                 q;
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		n = $urandom_range(20, 40);
		ccw = $urandom_range(0, 1);
		send_vertex(CENTRE, CENTRE, 1'b1);
		for (int k = 0; k < n; k++) begin
			a = CENTRE - 30'd1 - 30'($urandom_range(0, 1023));
			q = ccw ? (k % 4) : (3 - (k % 4));
			x = (q == 0 || q == 3) ? CENTRE + a : CENTRE - a;
			y = (q < 2) ? CENTRE + a : CENTRE - a;
			send_vertex(x, y, 1'b0);
		end
	endtask

	task automatic send_polygon();
		int                 kind;
		int                 n;
		int                 span;
		logic [COORD_W-1:0] mask;
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] base_y;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			send_winding();
		end else if (kind < 20) begin
			n = $urandom_range(1, 2);
			for (int k = 0; k < n; k++)
				send_vertex(30'($urandom()), 30'($urandom()), k == 0);
		end else if (kind < 30) begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++)
				send_vertex(30'($urandom()), 30'($urandom()), $urandom_range(0, 3) == 0);
		end else begin
			n = $urandom_range(3, 12);
			span = $urandom_range(1, COORD_W);
			mask = COORD_TOP >> (COORD_W - span);
			base_x = 30'($urandom());
			base_y = 30'($urandom());
			for (int k = 0; k < n; k++)
				send_vertex(base_x + (30'($urandom()) & mask), base_y + (30'($urandom()) & mask),
					(k == 0) && ($urandom_range(0, 9) != 0));
		end
	endtask

	initial begin
		int zoom_plan[9];
		int target;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		new_polygon = 1'b0;
		gap_en = 0;
		stall_en = 0;
		vertices_sent = 0;
		zoom_plan = '{0, 22, 31, 3, 11, 23, 16, 7, 0};
		zoom_plan[8] = $urandom_range(0, 31);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_zoom(5'd0);
		stall_en = 1;
		send_vertex(30'd5, 30'd7, 1'b0);
		send_vertex(30'd9, 30'd9, 1'b0);
		send_square(1'b1);
		send_vertex('0, '0, 1'b0);
		send_vertex(30'd100, 30'd200, 1'b1);
		send_vertex(30'd100, 30'd200, 1'b0);
		send_vertex(30'd101, 30'd200, 1'b0);
		send_vertex(30'd101, 30'd201, 1'b0);
		send_vertex(COORD_TOP, COORD_TOP, 1'b1);
		send_vertex('0, '0, 1'b0);
		send_vertex(COORD_TOP, '0, 1'b0);
		set_zoom(5'd22);
		send_square(1'b1);
		set_zoom(5'd31);
		send_square(1'b1);

		foreach (zoom_plan[p]) begin
			set_zoom(5'(zoom_plan[p]));
			gap_en = $urandom_range(0, 2) != 0;
			stall_en = $urandom_range(0, 2) != 0;
			target = vertices_sent + PHASE_ITEMS;
			while (vertices_sent < target)
				send_polygon();
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("mercator_polygon_area_top_test: done, clean");
		else
			$display("mercator_polygon_area_top_test: done, errors");
		$finish;
	end

endmodule
